[src/clnp_pkg.sv]
// shared types and constants for the chained-length name list parser
// no dependencies
package clnp_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int NAME_LIMIT  = 64;
  localparam int ENTRY_W     = 9;
  localparam int POS_W       = 6;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [5:0] {
    PH_HDR_COUNT = 6'b000001,
    PH_HDR_LEN   = 6'b000010,
    PH_NAME      = 6'b000100,
    PH_NEXT_LEN  = 6'b001000,
    PH_DONE      = 6'b010000,
    PH_HALT      = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         entry_index;
    logic [31:0]        entry_offset;
    logic [POS_W-1:0]   char_pos;
    logic [7:0]         char_value;
    logic               name_end;
    status_t            status;
    logic [31:0]        header_count;
    logic [ENTRY_W-1:0] entries_found;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } q_push_t;

endpackage

[src/chained_length_name_list_parser.sv]
// Byte-stream parser for a chained-length list of names.
// Input channel: in_valid / in_stall with in_data_byte and in_last_byte, one buffer
// byte per item; in_last_byte marks the final byte of a buffer.
// Result channel: out_valid / out_stall with the out_ fields; kind 0 is a name
// character, kind 1 an empty name, kind 2 the final status after the last byte.
// An accepted byte updates the parse state, and its results enter the registered result
// queue and are shown on the result channel behind any results still waiting there.
// Throughput is one byte per cycle while in_stall is low; the final byte may give two
// results (a name character or empty name, and the status), which drain one per
// unstalled cycle through a four-item queue. in_stall rises when the queue cannot take
// two more items, that is while three or more results wait; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to the
// start of a buffer; after each final byte the parser returns there by itself.
// depends on clnp_pkg, clnp_result_q
module chained_length_name_list_parser import clnp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_entry_index,
  output logic [31:0]        out_entry_offset,
  output logic [5:0]         out_char_pos,
  output logic [7:0]         out_char_value,
  output logic               out_name_end,
  output logic [1:0]         out_status,
  output logic [31:0]        out_header_count,
  output logic [8:0]         out_entries_found
);

  phase_t             phase_r, phase_nxt;
  logic [31:0]        byte_off_r, byte_off_nxt;
  logic [31:0]        field_r, field_nxt;
  logic [1:0]         fcnt_r, fcnt_nxt;
  logic [31:0]        declared_r, declared_nxt;
  logic [ENTRY_W-1:0] entries_r, entries_nxt;
  logic [POS_W-1:0]   name_rem_r, name_rem_nxt;
  logic [POS_W-1:0]   name_pos_r, name_pos_nxt;
  logic [31:0]        name_start_r, name_start_nxt;
  status_t            err_r, err_nxt;

  logic               in_acc;
  logic               q_full;
  logic [31:0]        next_off;
  logic [31:0]        fld_val;
  logic [ENTRY_W-1:0] entries_inc;
  logic               hdr_done;
  result_t            res0, res1;
  logic               res0_vld, res1_vld;
  q_push_t            push;
  result_t            head;

  assign in_stall    = q_full;
  assign in_acc      = in_valid && !q_full;
  assign next_off    = byte_off_r + 32'd1;
  assign fld_val     = {in_data_byte, field_r[23:0]};
  assign entries_inc = entries_r + ENTRY_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    byte_off_nxt   = byte_off_r;
    field_nxt      = field_r;
    fcnt_nxt       = fcnt_r;
    declared_nxt   = declared_r;
    entries_nxt    = entries_r;
    name_rem_nxt   = name_rem_r;
    name_pos_nxt   = name_pos_r;
    name_start_nxt = name_start_r;
    err_nxt        = err_r;
    res0           = '0;
    res1           = '0;
    res0_vld       = 1'b0;
    res1_vld       = 1'b0;
    hdr_done       = 1'b0;
    if (in_acc) begin
      case (phase_r)
        PH_HDR_COUNT, PH_HDR_LEN, PH_NEXT_LEN: begin
          if (fcnt_r == 2'd3) begin
            field_nxt = '0;
            fcnt_nxt  = '0;
            if (phase_r == PH_HDR_COUNT) begin
              declared_nxt = fld_val;
              phase_nxt    = PH_HDR_LEN;
            end else if (32'(entries_r) >= declared_r) begin
              phase_nxt = PH_DONE;
            end else if (32'(entries_r) >= 32'(MAX_ENTRIES)) begin
              if (err_r == ST_OK) err_nxt = ST_PARSE;
              phase_nxt = PH_HALT;
            end else if (fld_val >= 32'(NAME_LIMIT)) begin
              if (err_r == ST_OK) err_nxt = ST_TRUNC;
              phase_nxt = PH_HALT;
            end else begin
              name_start_nxt = next_off;
              name_pos_nxt   = '0;
              if (fld_val == 32'd0) begin
                res0_vld           = 1'b1;
                res0.kind          = KIND_EMPTY;
                res0.entry_index   = entries_r[7:0];
                res0.entry_offset  = next_off;
                entries_nxt        = entries_inc;
                phase_nxt = (32'(entries_inc) < declared_r) ? PH_NEXT_LEN : PH_DONE;
              end else begin
                name_rem_nxt = fld_val[POS_W-1:0];
                phase_nxt    = PH_NAME;
              end
            end
          end else begin
            field_nxt = field_r | (32'(in_data_byte) << {fcnt_r, 3'b000});
            fcnt_nxt  = fcnt_r + 2'd1;
          end
        end
        PH_NAME: begin
          res0_vld          = 1'b1;
          res0.kind         = KIND_CHAR;
          res0.entry_index  = entries_r[7:0];
          res0.entry_offset = name_start_r;
          res0.char_pos     = name_pos_r;
          res0.char_value   = in_data_byte;
          res0.name_end     = (name_rem_r == POS_W'(1));
          name_pos_nxt      = name_pos_r + POS_W'(1);
          name_rem_nxt      = name_rem_r - POS_W'(1);
          if (name_rem_r == POS_W'(1)) begin
            entries_nxt = entries_inc;
            phase_nxt = (32'(entries_inc) < declared_r) ? PH_NEXT_LEN : PH_DONE;
          end
        end
        PH_DONE: begin
          if (err_r == ST_OK) err_nxt = ST_PARSE;
          phase_nxt = PH_HALT;
        end
        default: begin
        end
      endcase
      byte_off_nxt = next_off;
      if (in_last_byte) begin
        hdr_done           = !(phase_nxt inside {PH_HDR_COUNT, PH_HDR_LEN});
        res1_vld           = 1'b1;
        res1.kind          = KIND_STATUS;
        res1.header_count  = hdr_done ? declared_nxt : 32'd0;
        res1.entries_found = entries_nxt;
        if (err_nxt != ST_OK) res1.status = err_nxt;
        else if (!hdr_done) res1.status = ST_PARSE;
        else if (phase_nxt == PH_DONE) res1.status = ST_OK;
        else res1.status = ST_TRUNC;
        phase_nxt      = PH_HDR_COUNT;
        byte_off_nxt   = '0;
        field_nxt      = '0;
        fcnt_nxt       = '0;
        declared_nxt   = '0;
        entries_nxt    = '0;
        name_rem_nxt   = '0;
        name_pos_nxt   = '0;
        name_start_nxt = '0;
        err_nxt        = ST_OK;
      end
    end
  end

  always_comb begin
    push.n      = 2'(res0_vld) + 2'(res1_vld);
    push.first  = res0_vld ? res0 : res1;
    push.second = res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR_COUNT;
      byte_off_r   <= '0;
      field_r      <= '0;
      fcnt_r       <= '0;
      declared_r   <= '0;
      entries_r    <= '0;
      name_rem_r   <= '0;
      name_pos_r   <= '0;
      name_start_r <= '0;
      err_r        <= ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      byte_off_r   <= byte_off_nxt;
      field_r      <= field_nxt;
      fcnt_r       <= fcnt_nxt;
      declared_r   <= declared_nxt;
      entries_r    <= entries_nxt;
      name_rem_r   <= name_rem_nxt;
      name_pos_r   <= name_pos_nxt;
      name_start_r <= name_start_nxt;
      err_r        <= err_nxt;
    end
  end

  clnp_result_q u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind          = head.kind;
  assign out_entry_index   = head.entry_index;
  assign out_entry_offset  = head.entry_offset;
  assign out_char_pos      = head.char_pos;
  assign out_char_value    = head.char_value;
  assign out_name_end      = head.name_end;
  assign out_status        = head.status;
  assign out_header_count  = head.header_count;
  assign out_entries_found = head.entries_found;

`ifndef ASSERT_OFF
  a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(entries_r) <= 32'(MAX_ENTRIES))
    else $error("entry count beyond limit");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (phase_r == PH_HDR_COUNT && byte_off_r == 32'd0
                                  && err_r == ST_OK))
    else $error("parser not back at buffer start after final byte");

  a_name_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> (name_rem_r != '0))
    else $error("name phase with nothing left to take");
`endif

endmodule

[src/clnp_result_q.sv]
// result queue: takes up to two items a cycle, gives one a cycle while out_stall is low
// depends on clnp_pkg
module clnp_result_q import clnp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  result_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign full      = (cnt_r > QCNT_W'(QDEPTH - 2));
  assign head      = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + QPTR_W'(push.n);
    rptr_nxt = rptr_r + QPTR_W'(pop);
    cnt_nxt  = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      q_r[wptr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> !full)
    else $error("push into full result queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == $past(cnt_r) + QCNT_W'($past(push.n)) - QCNT_W'($past(pop))))
    else $error("result queue count mismatch");
`endif

endmodule

[verif/testbench.sv]
// self-checking testbench for chained_length_name_list_parser: drives byte buffers with
// random gaps and a patterned result stall, predicts every result in lockstep
// depends on clnp_pkg and the parser rtl only
module testbench;
  import clnp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 360;
  localparam int REPORT_LINES = 30;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_entry_index;
  logic [31:0] out_entry_offset;
  logic [5:0]  out_char_pos;
  logic [7:0]  out_char_value;
  logic        out_name_end;
  logic [1:0]  out_status;
  logic [31:0] out_header_count;
  logic [8:0]  out_entries_found;

  chained_length_name_list_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_entry_index   (out_entry_index),
    .out_entry_offset  (out_entry_offset),
    .out_char_pos      (out_char_pos),
    .out_char_value    (out_char_value),
    .out_name_end      (out_name_end),
    .out_status        (out_status),
    .out_header_count  (out_header_count),
    .out_entries_found (out_entries_found)
  );

  always #5 clk = ~clk;

  result_t    pending_results[$];
  logic [7:0] frame_bytes[$];
  int         mismatch_count = 0;
  int         results_checked = 0;
  int         frames_sent = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  int         status_seen[3] = '{0, 0, 0};

  // parser state as predicted
  phase_t      pr_phase;
  logic [31:0] pr_offset;
  logic [31:0] pr_field;
  logic [1:0]  pr_field_bytes;
  logic [31:0] pr_declared;
  logic [8:0]  pr_entries;
  logic [5:0]  pr_name_left;
  logic [5:0]  pr_name_pos;
  logic [31:0] pr_name_start;
  status_t     pr_error;

  function automatic result_t pack_result(kind_t k, logic [7:0] idx, logic [31:0] ofs,
                                          logic [5:0] pos, logic [7:0] ch, logic ne,
                                          status_t st, logic [31:0] gc, logic [8:0] found);
    result_t r;
    r.kind          = k;
    r.entry_index   = idx;
    r.entry_offset  = ofs;
    r.char_pos      = pos;
    r.char_value    = ch;
    r.name_end      = ne;
    r.status        = st;
    r.header_count  = gc;
    r.entries_found = found;
    return r;
  endfunction

  function automatic void clear_parser();
    pr_phase       = PH_HDR_COUNT;
    pr_offset      = '0;
    pr_field       = '0;
    pr_field_bytes = '0;
    pr_declared    = '0;
    pr_entries     = '0;
    pr_name_left   = '0;
    pr_name_pos    = '0;
    pr_name_start  = '0;
    pr_error       = ST_OK;
  endfunction

  function automatic void flag_error(status_t code);
    if (pr_error == ST_OK) pr_error = code;
    pr_phase = PH_HALT;
  endfunction

  function automatic void close_name();
    pr_phase = (32'(pr_entries) < pr_declared) ? PH_NEXT_LEN : PH_DONE;
  endfunction

  function automatic void open_entry(logic [31:0] len, logic [31:0] start);
    if (32'(pr_entries) >= pr_declared) begin
      pr_phase = PH_DONE;
    end else if (pr_entries >= MAX_ENTRIES) begin
      flag_error(ST_PARSE);
    end else if (len >= NAME_LIMIT) begin
      flag_error(ST_TRUNC);
    end else begin
      pr_name_start = start;
      pr_name_pos   = '0;
      if (len == 32'd0) begin
        pending_results.push_back(pack_result(KIND_EMPTY, pr_entries[7:0], start, 6'd0,
                                              8'd0, 1'b0, ST_OK, 32'd0, 9'd0));
        pr_entries++;
        close_name();
      end else begin
        pr_name_left = len[5:0];
        pr_phase     = PH_NAME;
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last_flag);
    logic [31:0] next_off;
    logic [31:0] word;
    logic        hdr_done;
    status_t     st;
    next_off = pr_offset + 32'd1;
    case (pr_phase)
      PH_HDR_COUNT, PH_HDR_LEN, PH_NEXT_LEN: begin
        pr_field = pr_field | (32'(b) << {pr_field_bytes, 3'b000});
        if (pr_field_bytes == 2'd3) begin
          word           = pr_field;
          pr_field       = '0;
          pr_field_bytes = '0;
          if (pr_phase == PH_HDR_COUNT) begin
            pr_declared = word;
            pr_phase    = PH_HDR_LEN;
          end else begin
            open_entry(word, next_off);
          end
        end else begin
          pr_field_bytes++;
        end
      end
      PH_NAME: begin
        pending_results.push_back(pack_result(KIND_CHAR, pr_entries[7:0], pr_name_start,
                                              pr_name_pos, b, pr_name_left == 6'd1, ST_OK,
                                              32'd0, 9'd0));
        pr_name_pos++;
        pr_name_left--;
        if (pr_name_left == 6'd0) begin
          pr_entries++;
          close_name();
        end
      end
      PH_DONE: flag_error(ST_PARSE);
      default: ;
    endcase
    pr_offset = next_off;
    if (last_flag) begin
      hdr_done = (pr_phase != PH_HDR_COUNT) && (pr_phase != PH_HDR_LEN);
      if (pr_error != ST_OK) st = pr_error;
      else if (!hdr_done) st = ST_PARSE;
      else if (pr_phase == PH_DONE) st = ST_OK;
      else st = ST_TRUNC;
      pending_results.push_back(pack_result(KIND_STATUS, 8'd0, 32'd0, 6'd0, 8'd0, 1'b0, st,
                                            hdr_done ? pr_declared : 32'd0, pr_entries));
      status_seen[st]++;
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
               want);
    mismatch_count++;
  endtask

  // one buffer byte per item, sender in bursts with gaps
  task automatic send_byte(logic [7:0] b, logic last_flag);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last_flag;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    parse_byte(b, last_flag);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_word(logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) frame_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_noise(int count);
    repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_random_frame();
    int          shape;
    int          names;
    int          long_at;
    int          j;
    logic [31:0] declared;
    logic [31:0] len;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      add_noise($urandom_range(1, 24));
      return;
    end
    names    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
    declared = names;
    if (shape >= 80 && shape < 88) begin
      case ($urandom_range(0, 2))
        0: declared = names + $urandom_range(1, 3);
        1: declared = (names > 0) ? $urandom_range(0, names - 1) : 0;
        default: declared = 32'hFFFF_FFFF;
      endcase
    end
    add_word(declared);
    long_at = (shape >= 70 && shape < 80) ? $urandom_range(0, (names > 0) ? names - 1 : 0) : -1;
    for (j = 0; j < ((names > 0) ? names : 1); j++) begin
      if (j == long_at)
        len = $urandom_range(0, 1) ? 32'($urandom_range(NAME_LIMIT, NAME_LIMIT + 16))
                                   : ($urandom | 32'h40);
      else if ($urandom_range(0, 9) == 0)
        len = $urandom_range(9, NAME_LIMIT - 1);
      else
        len = $urandom_range(0, 8);
      add_word(len);
      if (len >= NAME_LIMIT) begin
        add_noise($urandom_range(0, 3));
        break;
      end
      if (names > 0) add_noise(len);
    end
    if (shape >= 88 && shape < 94) add_noise($urandom_range(1, 4));
    if (shape >= 94) repeat ($urandom_range(1, frame_bytes.size() - 1)) frame_bytes.pop_back();
  endfunction

  task automatic test_directed();
    int i;
    // final mark on the very first byte
    frame_bytes.push_back(8'hFF);
    send_frame();
    // header cut short
    frame_bytes = '{8'h01, 8'h00, 8'h00};
    send_frame();
    // no entries declared
    add_word(32'd0);
    add_word(32'd5);
    send_frame();
    // empty name, then a one-character name on the final byte
    add_word(32'd2);
    add_word(32'd0);
    add_word(32'd1);
    frame_bytes.push_back(8'hFF);
    send_frame();
    // name length at the limit
    add_word(32'd1);
    add_word(NAME_LIMIT);
    send_frame();
    // trailing bytes, error held to the end
    add_word(32'd1);
    add_word(32'd1);
    frame_bytes.push_back(8'h41);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame();
    // ends inside a length field
    add_word(32'd2);
    add_word(32'd0);
    frame_bytes.push_back(8'h03);
    frame_bytes.push_back(8'h00);
    send_frame();
    // ends inside a name
    add_word(32'd1);
    add_word(32'd3);
    frame_bytes.push_back(8'h61);
    frame_bytes.push_back(8'h62);
    send_frame();
    // largest count and longest allowed name
    add_word(32'hFFFF_FFFF);
    add_word(NAME_LIMIT - 1);
    for (i = 0; i < NAME_LIMIT - 1; i++) frame_bytes.push_back(8'(255 - 4 * i));
    send_frame();
  endtask

  task automatic test_entry_limit();
    int          i;
    logic [31:0] len;
    add_word(MAX_ENTRIES + 44);
    add_word(32'd0);
    for (i = 1; i <= MAX_ENTRIES; i++) begin
      len = $urandom_range(0, 1);
      add_word(len);
      add_noise(len);
    end
    send_frame();
  endtask

  task automatic test_random_frames();
    int   target;
    int   halfway;
    logic paused;
    target  = bytes_sent + RANDOM_BYTES;
    halfway = bytes_sent + RANDOM_BYTES / 2;
    paused  = 1'b0;
    while (bytes_sent < target) begin
      build_random_frame();
      send_frame();
      if (!paused && bytes_sent >= halfway) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_timer = 0;
  int          stall_phase = 0;

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(20, 150);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    stall_phase <= (stall_phase + 1) % 7;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= (stall_phase < 3);
    endcase
  end

  // outputs are stable at the falling edge; a result shown there with no stall is taken
  always @(negedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = pack_result(kind_t'(out_kind), out_entry_index, out_entry_offset, out_char_pos,
                        out_char_value, out_name_end, status_t'(out_status), out_header_count,
                        out_entries_found);
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, kind", got.kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.entry_index !== want.entry_index)
          report_mismatch("entry_index", got.entry_index, want.entry_index);
        if (got.entry_offset !== want.entry_offset)
          report_mismatch("entry_offset", got.entry_offset, want.entry_offset);
        if (got.char_pos !== want.char_pos)
          report_mismatch("char_pos", got.char_pos, want.char_pos);
        if (got.char_value !== want.char_value)
          report_mismatch("char_value", got.char_value, want.char_value);
        if (got.name_end !== want.name_end)
          report_mismatch("name_end", got.name_end, want.name_end);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.header_count !== want.header_count)
          report_mismatch("header_count", got.header_count, want.header_count);
        if (got.entries_found !== want.entries_found)
          report_mismatch("entries_found", got.entries_found, want.entries_found);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_entry_limit();
    wait_drained();
    test_random_frames();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d buffers, %0d bytes, %0d results compared, %0d mismatches", frames_sent,
             bytes_sent, results_checked, mismatch_count);
    $display("final status: ok %0d, parse error %0d, truncated %0d", status_seen[ST_OK],
             status_seen[ST_PARSE], status_seen[ST_TRUNC]);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
